// File: rtl/core/assert_macros.svh
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent check on clk_i, off during reset.
`define LPU_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Condition in one cycle implies a result in the next.
`define LPU_ASSERT_NEXT(lbl, pre, post, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |=> (post)) \
    else $error(msg);

`endif

// File: rtl/core/lpu_pkg.sv
package lpu_pkg;

  localparam int unsigned HEADER_BYTES    = 32;
  localparam int unsigned PALETTE_ENTRIES = 16;
  localparam int unsigned PAL_AW          = $clog2(PALETTE_ENTRIES);
  localparam int unsigned CFG_W           = 11;
  localparam int unsigned CFG_IDX_W       = 2;

  localparam logic [CFG_IDX_W-1:0] CFG_ARGB_MODE   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_LINE_WIDTH  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_FRAME_LINES = 2'd2;

  localparam logic [CFG_W-1:0] LINE_WIDTH_RST  = 11'd480;
  localparam logic [CFG_W-1:0] FRAME_LINES_RST = 11'd160;

  localparam logic [7:0] ARGB_ALPHA = 8'hFF;

  // 16-level ramp, indexed by 15 - p[3:0]: k * level / 15.
  localparam logic [7:0] RAMP_R [PALETTE_ENTRIES] = '{
    8'd0, 8'd10, 8'd20, 8'd30, 8'd40, 8'd51, 8'd61, 8'd71,
    8'd81, 8'd91, 8'd102, 8'd112, 8'd122, 8'd132, 8'd142, 8'd153};
  localparam logic [7:0] RAMP_G [PALETTE_ENTRIES] = '{
    8'd0, 8'd11, 8'd22, 8'd34, 8'd45, 8'd56, 8'd68, 8'd79,
    8'd90, 8'd102, 8'd113, 8'd124, 8'd136, 8'd147, 8'd158, 8'd170};
  localparam logic [7:0] RAMP_B [PALETTE_ENTRIES] = '{
    8'd0, 8'd9, 8'd18, 8'd27, 8'd36, 8'd45, 8'd54, 8'd63,
    8'd72, 8'd81, 8'd90, 8'd99, 8'd108, 8'd117, 8'd126, 8'd136};

  typedef enum logic [1:0] {
    DEPTH_1BPP = 2'd0,
    DEPTH_2BPP = 2'd1,
    DEPTH_4BPP = 2'd2,
    DEPTH_8BPP = 2'd3
  } lpu_depth_e;

  typedef enum logic {
    ST_IDLE,
    ST_UNPACK
  } lpu_state_e;

  typedef struct packed {
    logic [7:0] mem_byte;
    logic       frame_start;
  } lpu_in_t;

  typedef struct packed {
    logic [31:0] color;
    logic [9:0]  column;
    logic [9:0]  row;
    logic        last_of_byte;
    logic        end_of_line;
    logic        end_of_frame;
  } lpu_out_t;

  typedef struct packed {
    logic              en;
    logic              hi;
    logic [PAL_AW-1:0] addr;
    logic [7:0]        data;
  } lpu_pal_wr_t;

  typedef struct packed {
    logic busy;
    logic hdr_done;
  } lpu_stat_t;

endpackage

// File: rtl/core/lcd_palette_pixel_unpacker_core.sv
// Palette pixel unpacker. A frame starts with the request marked frame_start;
// the first 32 bytes load the 16-entry palette and the depth code and give no
// pixels. Each later byte is taken and then unpacked one pixel per cycle, while
// the output is not stalled, through the single palette lookup and color path:
// 8, 4, 2 or 1 pixels at 1, 2, 4 or 8 bpp. in_stall_o is high while a byte is
// being unpacked. The output register lets the next byte be taken while the
// last pixel still waits. Config must be written only while the block is idle;
// the block itself does not enforce this.
`include "assert_macros.svh"

module lcd_palette_pixel_unpacker_core import lpu_pkg::*; #(
  parameter int unsigned MAX_LINE_PIXELS = 1024,
  parameter int unsigned MAX_FRAME_LINES = 1024
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  lpu_in_t              in_req_i,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output lpu_out_t             out_req_o,
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_index_i,
  input  logic [CFG_W-1:0]     cfg_wdata_i
);

  localparam int unsigned COL_W  = $clog2(MAX_LINE_PIXELS);
  localparam int unsigned ROW_W  = (MAX_FRAME_LINES > 1) ? $clog2(MAX_FRAME_LINES) : 1;
  localparam int unsigned WCMP_W = (COL_W + 1 > CFG_W) ? COL_W + 1 : CFG_W;
  localparam int unsigned LCMP_W = (ROW_W + 1 > CFG_W) ? ROW_W + 1 : CFG_W;

  logic             argb_mode_q;
  logic [CFG_W-1:0] line_width_q;
  logic [CFG_W-1:0] frame_lines_q;

  logic [WCMP_W-1:0] lw_ext, lw_clamp, lw_eff;
  logic [LCMP_W-1:0] fl_ext, fl_clamp, fl_eff;
  logic [COL_W-1:0]  width_last;
  logic [ROW_W-1:0]  lines_last;

  logic [PAL_AW-1:0] pal_idx;
  logic [31:0]       color;
  lpu_pal_wr_t       pal_wr;
  lpu_stat_t         stat;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      argb_mode_q   <= 1'b1;
      line_width_q  <= LINE_WIDTH_RST;
      frame_lines_q <= FRAME_LINES_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        CFG_ARGB_MODE:   argb_mode_q   <= cfg_wdata_i[0];
        CFG_LINE_WIDTH:  line_width_q  <= cfg_wdata_i;
        CFG_FRAME_LINES: frame_lines_q <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  // clamp both to the maximum, round width down to a multiple of 8, floor width at 8 and lines at 1
  assign lw_ext   = WCMP_W'(line_width_q);
  assign lw_clamp = (lw_ext > WCMP_W'(MAX_LINE_PIXELS)) ? WCMP_W'(MAX_LINE_PIXELS) : lw_ext;
  assign lw_eff   = (lw_clamp[WCMP_W-1:3] == '0) ? WCMP_W'(8) : {lw_clamp[WCMP_W-1:3], 3'd0};
  assign width_last = COL_W'(lw_eff - WCMP_W'(1));

  assign fl_ext   = LCMP_W'(frame_lines_q);
  assign fl_clamp = (fl_ext > LCMP_W'(MAX_FRAME_LINES)) ? LCMP_W'(MAX_FRAME_LINES) : fl_ext;
  assign fl_eff   = (fl_clamp == '0) ? LCMP_W'(1) : fl_clamp;
  assign lines_last = ROW_W'(fl_eff - LCMP_W'(1));

  lpu_seq #(
    .COL_W (COL_W),
    .ROW_W (ROW_W)
  ) u_seq (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .in_req_i     (in_req_i),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .out_req_o    (out_req_o),
    .width_last_i (width_last),
    .lines_last_i (lines_last),
    .color_i      (color),
    .pal_idx_o    (pal_idx),
    .pal_wr_o     (pal_wr),
    .stat_o       (stat)
  );

  lpu_palette u_palette (
    .clk_i       (clk_i),
    .wr_i        (pal_wr),
    .rd_idx_i    (pal_idx),
    .argb_mode_i (argb_mode_q),
    .color_o     (color)
  );

  `LPU_ASSERT(a_pal_wr_not_busy, pal_wr.en |-> !stat.busy, "palette write during unpack")
  `LPU_ASSERT(a_unpack_after_hdr, stat.busy |-> stat.hdr_done, "unpack before header done")
  `LPU_ASSERT_NEXT(a_busy_needs_req, !stat.busy && !(in_valid_i && !in_stall_o), !stat.busy, "unpack started without request")
  `LPU_ASSERT(a_eof_flags, (out_valid_o && out_req_o.end_of_frame) |-> (out_req_o.end_of_line && out_req_o.last_of_byte), "end of frame without line and byte end")

endmodule

// File: rtl/core/lpu_palette.sv
module lpu_palette import lpu_pkg::*; (
  input  logic              clk_i,
  input  lpu_pal_wr_t       wr_i,
  input  logic [PAL_AW-1:0] rd_idx_i,
  input  logic              argb_mode_i,
  output logic [31:0]       color_o
);

  logic [11:0] pal_q [PALETTE_ENTRIES];
  logic [11:0] pal_word;
  logic [3:0]  ramp_idx;

  always_ff @(posedge clk_i) begin
    if (wr_i.en) begin
      if (wr_i.hi) begin
        pal_q[wr_i.addr][11:8] <= wr_i.data[3:0];
      end else begin
        pal_q[wr_i.addr][7:0] <= wr_i.data;
      end
    end
  end

  assign pal_word = pal_q[rd_idx_i];
  assign ramp_idx = ~pal_word[3:0];

  always_comb begin
    if (argb_mode_i) begin
      color_o = {ARGB_ALPHA, RAMP_B[ramp_idx], RAMP_G[ramp_idx], RAMP_R[ramp_idx]};
    end else begin
      color_o = {24'd0, ~(pal_word[7:0] | {pal_word[3:0], 4'd0})};
    end
  end

endmodule

// File: rtl/core/lpu_seq.sv
module lpu_seq import lpu_pkg::*; #(
  parameter int unsigned COL_W = 10,
  parameter int unsigned ROW_W = 10
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  lpu_in_t           in_req_i,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output lpu_out_t          out_req_o,
  input  logic [COL_W-1:0]  width_last_i,
  input  logic [ROW_W-1:0]  lines_last_i,
  input  logic [31:0]       color_i,
  output logic [PAL_AW-1:0] pal_idx_o,
  output lpu_pal_wr_t       pal_wr_o,
  output lpu_stat_t         stat_o
);

  lpu_state_e       state_q, state_d;
  logic [5:0]       hdr_cnt_q, hdr_cnt_d;
  lpu_depth_e       depth_q, depth_d;
  logic [COL_W-1:0] col_q, col_d;
  logic [ROW_W-1:0] row_q, row_d;
  logic             frame_idle_q, frame_idle_d;
  logic [2:0]       k_q, k_d;
  logic [7:0]       byte_q, byte_d;
  logic             out_valid_q, out_valid_d;
  lpu_out_t         out_q, out_d;

  logic       in_acc, active, in_hdr, adv;
  logic [5:0] hdr_eff;
  logic [2:0] shamt, ppb_last;
  logic [7:0] field;
  logic       eol, eof, last;
  logic [31:0] col_ext, row_ext;

  assign in_acc  = in_valid_i && (state_q == ST_IDLE);
  assign active  = in_req_i.frame_start || !frame_idle_q;
  assign hdr_eff = in_req_i.frame_start ? 6'd0 : hdr_cnt_q;
  assign in_hdr  = (hdr_eff < 6'(HEADER_BYTES));
  assign adv     = (state_q == ST_UNPACK) && (!out_valid_q || !out_stall_i);

  assign pal_wr_o.en   = in_acc && active && in_hdr;
  assign pal_wr_o.hi   = hdr_eff[0];
  assign pal_wr_o.addr = hdr_eff[PAL_AW:1];
  assign pal_wr_o.data = in_req_i.mem_byte;

  assign shamt    = k_q << depth_q;
  assign field    = byte_q >> shamt;
  assign ppb_last = 3'((4'd8 >> depth_q) - 4'd1);

  always_comb begin
    unique case (depth_q)
      DEPTH_1BPP: pal_idx_o = {3'd0, field[0]};
      DEPTH_2BPP: pal_idx_o = {2'd0, field[1:0]};
      DEPTH_4BPP: pal_idx_o = field[3:0];
      DEPTH_8BPP: pal_idx_o = field[3:0];
      default:    pal_idx_o = field[3:0];
    endcase
  end

  assign eol  = (col_q >= width_last_i);
  assign eof  = eol && (row_q >= lines_last_i);
  assign last = (k_q == ppb_last) || eof;

  assign col_ext = 32'(col_q);
  assign row_ext = 32'(row_q);

  always_comb begin
    state_d      = state_q;
    hdr_cnt_d    = hdr_cnt_q;
    depth_d      = depth_q;
    col_d        = col_q;
    row_d        = row_q;
    frame_idle_d = frame_idle_q;
    k_d          = k_q;
    byte_d       = byte_q;
    out_valid_d  = out_valid_q && out_stall_i;
    out_d        = out_q;

    if (in_acc) begin
      if (in_req_i.frame_start) begin
        frame_idle_d = 1'b0;
        col_d        = '0;
        row_d        = '0;
      end
      if (active) begin
        if (in_hdr) begin
          hdr_cnt_d = hdr_eff + 6'd1;
          if (hdr_eff == 6'd1) begin
            depth_d = lpu_depth_e'(in_req_i.mem_byte[5:4]);
          end
        end else begin
          byte_d  = in_req_i.mem_byte;
          k_d     = 3'd0;
          state_d = ST_UNPACK;
        end
      end
    end

    if (adv) begin
      out_valid_d        = 1'b1;
      out_d.color        = color_i;
      out_d.column       = col_ext[9:0];
      out_d.row          = row_ext[9:0];
      out_d.last_of_byte = last;
      out_d.end_of_line  = eol;
      out_d.end_of_frame = eof;
      if (eol) begin
        col_d = '0;
        row_d = row_q + ROW_W'(1);
      end else begin
        col_d = col_q + COL_W'(1);
      end
      if (eof) begin
        frame_idle_d = 1'b1;
        col_d        = '0;
        row_d        = '0;
      end
      if (last) begin
        state_d = ST_IDLE;
      end else begin
        k_d = k_q + 3'd1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      hdr_cnt_q    <= '0;
      depth_q      <= DEPTH_1BPP;
      col_q        <= '0;
      row_q        <= '0;
      frame_idle_q <= 1'b1;
      k_q          <= '0;
      out_valid_q  <= 1'b0;
    end else begin
      state_q      <= state_d;
      hdr_cnt_q    <= hdr_cnt_d;
      depth_q      <= depth_d;
      col_q        <= col_d;
      row_q        <= row_d;
      frame_idle_q <= frame_idle_d;
      k_q          <= k_d;
      out_valid_q  <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    byte_q <= byte_d;
    out_q  <= out_d;
  end

  assign in_stall_o      = (state_q != ST_IDLE);
  assign out_valid_o     = out_valid_q;
  assign out_req_o       = out_q;
  assign stat_o.busy     = (state_q == ST_UNPACK);
  assign stat_o.hdr_done = !(hdr_cnt_q < 6'(HEADER_BYTES));

endmodule

// File: tb/lcd_palette_pixel_unpacker_core_test.sv
module lcd_palette_pixel_unpacker_core_test;
  import lpu_pkg::*;

  localparam int unsigned MAX_LINE_PIXELS = 1024;
  localparam int unsigned MAX_FRAME_LINES = 1024;
  localparam int unsigned RAMP_R_TOP      = 'h99;
  localparam int unsigned RAMP_G_TOP      = 'hAA;
  localparam int unsigned RAMP_B_TOP      = 'h88;
  localparam int unsigned QUIET_LIMIT     = 2000;
  localparam int unsigned SETTLE_CYCLES   = 16;
  localparam int unsigned RANDOM_BYTES    = 24;

  logic                 clk_i       = 1'b0;
  logic                 rst_ni      = 1'b0;
  logic                 in_valid_i  = 1'b0;
  logic                 in_stall_o;
  lpu_in_t              in_req_i    = '0;
  logic                 out_valid_o;
  logic                 out_stall_i = 1'b0;
  lpu_out_t             out_req_o;
  logic                 cfg_we_i    = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index_i = CFG_ARGB_MODE;
  logic [CFG_W-1:0]     cfg_wdata_i = '0;

  lcd_palette_pixel_unpacker_core #(
    .MAX_LINE_PIXELS(MAX_LINE_PIXELS),
    .MAX_FRAME_LINES(MAX_FRAME_LINES)
  ) dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_req_i   (in_req_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_req_o  (out_req_o),
    .cfg_we_i   (cfg_we_i),
    .cfg_index_i(cfg_index_i),
    .cfg_wdata_i(cfg_wdata_i)
  );

  // shadow of the block's registers and state
  logic             mode_argb    = 1'b1;
  logic [CFG_W-1:0] line_width   = LINE_WIDTH_RST;
  logic [CFG_W-1:0] frame_height = FRAME_LINES_RST;
  int unsigned      hdr_pos      = 0;
  logic [11:0]      pal_words [PALETTE_ENTRIES];
  lpu_depth_e       cur_depth    = DEPTH_1BPP;
  int unsigned      pix_col      = 0;
  int unsigned      pix_row      = 0;
  bit               frame_off    = 1'b1;

  lpu_out_t    expected_pixels [$];
  int unsigned mismatch_count = 0;
  int unsigned counted_bytes  = 0;
  int unsigned quiet_cycles   = 0;
  bit          in_idle        = 1'b1;
  bit          out_idle       = 1'b1;

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  function automatic int unsigned eff_width();
    int unsigned w;
    w = (line_width > MAX_LINE_PIXELS) ? MAX_LINE_PIXELS : line_width;
    w = w - (w % 8);
    return (w < 8) ? 8 : w;
  endfunction

  function automatic int unsigned eff_lines();
    int unsigned n;
    n = (frame_height > MAX_FRAME_LINES) ? MAX_FRAME_LINES : frame_height;
    return (n < 1) ? 1 : n;
  endfunction

  function automatic logic [31:0] ramp_word(logic [11:0] p);
    int unsigned lvl;
    lvl = 15 - p[3:0];
    return {ARGB_ALPHA, 8'(RAMP_B_TOP * lvl / 15), 8'(RAMP_G_TOP * lvl / 15),
            8'(RAMP_R_TOP * lvl / 15)};
  endfunction

  function automatic logic [31:0] gray_word(logic [11:0] p);
    return {24'h0, 8'((p | (p << 4)) ^ 12'h0FF)};
  endfunction

  // pixels caused by one accepted request
  function automatic void unpack_byte(lpu_in_t req);
    int unsigned width, lines, bpp, ppb, idx, ent;
    bit eol, eof;
    logic [11:0] p;
    lpu_out_t px;
    if (req.frame_start) begin
      frame_off = 1'b0;
      hdr_pos   = 0;
      pix_col   = 0;
      pix_row   = 0;
    end else if (frame_off) begin
      return;
    end
    if (hdr_pos < HEADER_BYTES) begin
      ent = hdr_pos / 2;
      if (hdr_pos % 2 == 0) begin
        pal_words[ent][7:0] = req.mem_byte;
      end else begin
        pal_words[ent][11:8] = req.mem_byte[3:0];
        if (hdr_pos == 1) cur_depth = lpu_depth_e'(req.mem_byte[5:4]);
      end
      hdr_pos++;
      return;
    end
    width = eff_width();
    lines = eff_lines();
    bpp   = 1 << cur_depth;
    ppb   = 8 / bpp;
    for (int unsigned k = 0; k < ppb; k++) begin
      idx = ((req.mem_byte >> (k * bpp)) & ((1 << bpp) - 1)) % PALETTE_ENTRIES;
      p   = pal_words[idx];
      eol = pix_col >= width - 1;
      eof = eol && (pix_row >= lines - 1);
      px.color        = mode_argb ? ramp_word(p) : gray_word(p);
      px.column       = 10'(pix_col);
      px.row          = 10'(pix_row);
      px.last_of_byte = (k == ppb - 1) || eof;
      px.end_of_line  = eol;
      px.end_of_frame = eof;
      expected_pixels.push_back(px);
      if (eol) begin
        pix_col = 0;
        pix_row++;
      end else begin
        pix_col++;
      end
      if (eof) begin
        frame_off = 1'b1;
        pix_col   = 0;
        pix_row   = 0;
        break;
      end
    end
  endfunction

  task automatic send_byte(input logic [7:0] data, input bit fs);
    int unsigned gap;
    lpu_in_t req;
    req.mem_byte    = data;
    req.frame_start = fs;
    gap = in_idle ? $urandom_range(0, 7) : 0;
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_req_i   <= req;
    do @(posedge clk_i); while (in_stall_o);
    if (fs || !frame_off) counted_bytes++;
    unpack_byte(req);
  endtask

  // spread palette: entry e = e * 0x111, covers 0x000 and 0xFFF
  task automatic send_header(input lpu_depth_e depth, input int unsigned count,
                             input bit spread);
    logic [7:0] data;
    for (int unsigned i = 0; i < count; i++) begin
      if (!spread) data = 8'($urandom);
      else if (i % 2 == 1) data = {4'($urandom), 4'(i / 2)};
      else data = {4'(i / 2), 4'(i / 2)};
      if (i == 1) data[5:4] = depth;
      send_byte(data, i == 0);
    end
  endtask

  task automatic send_random_bytes(input int unsigned count);
    repeat (count) send_byte(8'($urandom), 1'b0);
  endtask

  task automatic wait_drained();
    in_valid_i <= 1'b0;
    while (expected_pixels.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] value);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= idx;
    cfg_wdata_i <= value;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    @(posedge clk_i);
    case (idx)
      CFG_ARGB_MODE:   mode_argb    = value[0];
      CFG_LINE_WIDTH:  line_width   = value;
      CFG_FRAME_LINES: frame_height = value;
      default: ;
    endcase
  endtask

  task automatic set_geometry(input logic [CFG_W-1:0] width, input logic [CFG_W-1:0] lines);
    wait_drained();
    write_reg(CFG_LINE_WIDTH, width);
    write_reg(CFG_FRAME_LINES, lines);
  endtask

  task automatic test_reset_defaults();
    send_random_bytes(3);
    send_header(DEPTH_1BPP, HEADER_BYTES, 1'b1);
    send_byte(8'h00, 1'b0);
    send_byte(8'hFF, 1'b0);
  endtask

  task automatic test_all_depths();
    for (int d = 1; d < 4; d++) begin
      wait_drained();
      write_reg(CFG_ARGB_MODE, {10'($urandom), 1'b1});
      send_header(lpu_depth_e'(d), HEADER_BYTES, 1'b1);
      send_byte(8'h00, 1'b0);
      send_byte(8'hFF, 1'b0);
      send_byte(8'hA5, 1'b0);
      wait_drained();
      write_reg(CFG_ARGB_MODE, {10'($urandom), 1'b0});
      send_byte(8'h5A, 1'b0);
      send_byte(8'h0F, 1'b0);
      send_byte(8'hF0, 1'b0);
    end
  endtask

  task automatic test_line_and_frame_end();
    set_geometry(11'd8, 11'd2);
    send_header(DEPTH_2BPP, HEADER_BYTES, 1'b1);
    send_random_bytes(4);
    // frame is over, these are dropped
    send_random_bytes(2);
  endtask

  task automatic test_restart();
    set_geometry(11'd16, 11'd2);
    send_header(DEPTH_1BPP, 6, 1'b1);
    send_header(DEPTH_1BPP, HEADER_BYTES, 1'b1);
    send_random_bytes(1);
    send_header(DEPTH_8BPP, HEADER_BYTES, 1'b0);
    send_random_bytes(3);
  endtask

  task automatic test_counters_past_limits();
    set_geometry(11'd64, 11'd8);
    send_header(DEPTH_1BPP, HEADER_BYTES, 1'b1);
    send_random_bytes(2);
    // column now beyond the new width: line ends on the first pixel
    set_geometry(11'd8, 11'd8);
    send_random_bytes(4);
    // row now beyond the new height: frame ends mid-byte
    set_geometry(11'd8, 11'd2);
    send_random_bytes(2);
  endtask

  task automatic test_size_extremes();
    // oversized width and height clamp to the maximum, gray at full rate
    set_geometry(11'd2047, 11'd2047);
    write_reg(CFG_ARGB_MODE, 11'd0);
    in_idle  = 1'b0;
    out_idle = 1'b0;
    send_header(DEPTH_1BPP, HEADER_BYTES, 1'b0);
    send_random_bytes(4);
    in_idle  = 1'b1;
    out_idle = 1'b1;
    // width 15 rounds down to 8
    set_geometry(11'd15, 11'd2047);
    send_random_bytes(2);
    // zero width and height floor at 8 and 1
    set_geometry(11'd0, 11'd0);
    write_reg(CFG_ARGB_MODE, 11'h7FF);
    send_random_bytes(2);
  endtask

  task automatic test_random_streams();
    int unsigned kind, ppb, nbytes;
    lpu_depth_e depth;
    counted_bytes = 0;
    while (counted_bytes < RANDOM_BYTES) begin
      if ($urandom_range(0, 2) == 0) begin
        wait_drained();
        write_reg(CFG_ARGB_MODE, CFG_W'($urandom));
        write_reg(CFG_LINE_WIDTH, ($urandom_range(0, 9) == 0) ?
                  CFG_W'($urandom) : CFG_W'($urandom_range(1, 8) * 8));
        write_reg(CFG_FRAME_LINES, ($urandom_range(0, 9) == 0) ?
                  CFG_W'($urandom) : CFG_W'($urandom_range(1, 4)));
      end
      in_idle  = $urandom_range(0, 3) != 0;
      out_idle = $urandom_range(0, 3) != 0;
      kind  = $urandom_range(0, 9);
      depth = lpu_depth_e'($urandom_range(0, 3));
      if (kind == 0) begin
        send_header(depth, $urandom_range(1, HEADER_BYTES - 1), 1'b0);
      end else if (kind == 1) begin
        send_random_bytes($urandom_range(1, 4));
      end else begin
        send_header(depth, HEADER_BYTES, $urandom_range(0, 3) == 0);
        ppb    = 8 >> depth;
        nbytes = (eff_width() * eff_lines() + ppb - 1) / ppb;
        if (nbytes > 16) nbytes = $urandom_range(1, 16);
        else if ($urandom_range(0, 4) == 0) nbytes = $urandom_range(1, nbytes);
        send_random_bytes(nbytes + (($urandom_range(0, 3) == 0) ? $urandom_range(1, 3) : 0));
      end
    end
    in_idle  = 1'b1;
    out_idle = 1'b1;
  endtask

  initial begin : out_stall_gen
    int unsigned hold;
    forever begin
      hold = out_idle ? $urandom_range(0, 7) : 0;
      if (hold > 0) begin
        out_stall_i <= 1'b1;
        repeat (hold) @(posedge clk_i);
      end
      out_stall_i <= 1'b0;
      do @(posedge clk_i); while (!(out_valid_o === 1'b1 && !out_stall_i));
    end
  end

  function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
    if (got !== want) begin
      $error("%s: expected %0h, got %0h", name, want, got);
      mismatch_count++;
    end
  endfunction

  always @(posedge clk_i) begin : pixel_check
    lpu_out_t want;
    if (rst_ni && out_valid_o === 1'b1 && !out_stall_i) begin
      if (expected_pixels.size() == 0) begin
        $error("pixel request with none expected: %p", out_req_o);
        mismatch_count++;
      end else begin
        want = expected_pixels.pop_front();
        check_field("color", want.color, out_req_o.color);
        check_field("column", want.column, out_req_o.column);
        check_field("row", want.row, out_req_o.row);
        check_field("last_of_byte", want.last_of_byte, out_req_o.last_of_byte);
        check_field("end_of_line", want.end_of_line, out_req_o.end_of_line);
        check_field("end_of_frame", want.end_of_frame, out_req_o.end_of_frame);
      end
    end
  end

  always @(posedge clk_i) begin
    if ((in_valid_i && in_stall_o === 1'b0) || (out_valid_o === 1'b1 && !out_stall_i)) begin
      quiet_cycles <= 0;
    end else if (rst_ni) begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("TB_ERROR");
        $finish;
      end
    end
  end

  initial begin
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_reset_defaults();
    test_all_depths();
    test_line_and_frame_end();
    test_restart();
    test_counters_past_limits();
    test_size_extremes();
    test_random_streams();
    wait_drained();
    if (mismatch_count == 0) $display("TB_OK");
    else $display("TB_ERROR");
    $finish;
  end

endmodule
